### hw/rtl/tcbs_pkg.sv
package tcbs_pkg;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 7;
  localparam int STEP_W = 4;
  localparam int MOD_W  = 3;

  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_NL    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_SUBST = 8'd63;
  localparam int         FIRST_CODE = 32;
  localparam int         CODE_COUNT = 100;

  localparam int SCREEN_W   = 800;
  localparam int SCREEN_H   = 480;
  localparam int FILL_COLOR = 'h0000;

  localparam logic [1:0] OP_GLYPH  = 2'd0;
  localparam logic [1:0] OP_SCROLL = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_GLYPH,
    EMIT_SCROLL,
    EMIT_FILL
  } emit_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ADVANCE,
    ACT_NEWLINE,
    ACT_SET
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_SET_MODE,
    C_IS_CR,
    C_IS_NL,
    C_MORE_TAB,
    C_NO_WRAP,
    C_NOT_BOTTOM
  } cond_t;

  typedef struct packed {
    emit_t             emit;
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // microcode step addresses
  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_CHK_SET  = 4'd1;
  localparam logic [STEP_W-1:0] S_CHK_CR   = 4'd2;
  localparam logic [STEP_W-1:0] S_CHK_NL   = 4'd3;
  localparam logic [STEP_W-1:0] S_GLYPH    = 4'd4;
  localparam logic [STEP_W-1:0] S_TAB_LOOP = 4'd5;
  localparam logic [STEP_W-1:0] S_CHK_WRAP = 4'd6;
  localparam logic [STEP_W-1:0] S_NEWLINE  = 4'd7;
  localparam logic [STEP_W-1:0] S_SCROLL   = 4'd8;
  localparam logic [STEP_W-1:0] S_FILL     = 4'd9;
  localparam logic [STEP_W-1:0] S_SET      = 4'd10;

  // jump to target when cond holds, otherwise fall through to the next step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{EMIT_NONE, ACT_NONE, C_ALWAYS, S_IDLE};
    unique case (step)
      S_CHK_SET:  w = '{EMIT_NONE,   ACT_NONE,    C_SET_MODE,   S_SET};
      S_CHK_CR:   w = '{EMIT_NONE,   ACT_NONE,    C_IS_CR,      S_IDLE};
      S_CHK_NL:   w = '{EMIT_NONE,   ACT_NONE,    C_IS_NL,      S_NEWLINE};
      S_GLYPH:    w = '{EMIT_GLYPH,  ACT_ADVANCE, C_NEVER,      S_IDLE};
      S_TAB_LOOP: w = '{EMIT_NONE,   ACT_NONE,    C_MORE_TAB,   S_GLYPH};
      S_CHK_WRAP: w = '{EMIT_NONE,   ACT_NONE,    C_NO_WRAP,    S_IDLE};
      S_NEWLINE:  w = '{EMIT_NONE,   ACT_NEWLINE, C_NOT_BOTTOM, S_IDLE};
      S_SCROLL:   w = '{EMIT_SCROLL, ACT_NONE,    C_NEVER,      S_IDLE};
      S_FILL:     w = '{EMIT_FILL,   ACT_NONE,    C_ALWAYS,     S_IDLE};
      S_SET:      w = '{EMIT_NONE,   ACT_SET,     C_ALWAYS,     S_IDLE};
      default:    w = '{EMIT_NONE,   ACT_NONE,    C_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

  typedef struct packed {
    emit_t            emit;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_req_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] src_x;
    logic [8:0] src_y;
    logic [9:0] dst_x;
    logic [8:0] dst_y;
    logic [9:0] rect_w;
    logic [8:0] rect_h;
  } cmd_t;

endpackage

### hw/rtl/tcbs_if.sv
interface tcbs_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;
  logic [7:0] new_col;
  logic [7:0] new_row;

  modport source (output valid, output mode, output char_code, output new_col,
                  output new_row, input ready);
  modport sink (input valid, input mode, input char_code, input new_col,
                input new_row, output ready);
endinterface

interface tcbs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [9:0] src_x;
  logic [8:0] src_y;
  logic [9:0] dst_x;
  logic [8:0] dst_y;
  logic [9:0] rect_w;
  logic [8:0] rect_h;
  logic       last;

  modport source (output valid, output op, output src_x, output src_y, output dst_x,
                  output dst_y, output rect_w, output rect_h, output last, input ready);
  modport sink (input valid, input op, input src_x, input src_y, input dst_x,
                input dst_y, input rect_w, input rect_h, input last, output ready);
endinterface

### hw/rtl/text_console_blit_sequencer_core.sv
// microcoded text console: one control step per cycle from a small program table
// except while a command waits in the output register; a request is taken only
// in idle, then the steps check for a cursor set, a carriage return and a newline,
// draw a glyph (repeated up to a tab column for a tab) and check for a wrap, and
// a newline on the bottom row emits a scroll and then a fill
// synchronous active-low reset: cursor at column 0 row 0, no command pending
module text_console_blit_sequencer_core import tcbs_pkg::*; #(
  parameter int COLS          = 40,
  parameter int ROWS          = 24,
  parameter int GLYPH_W       = 20,
  parameter int GLYPH_H       = 20,
  parameter int ATLAS_PER_ROW = 50,
  parameter int TAB_STOP      = 4
) (
  input logic       clk,
  input logic       rst_n,
  tcbs_in_if.sink   in_ch,
  tcbs_out_if.source out_ch
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              wrap_r, wrap_nxt;

  logic              mode_r, is_cr_r, is_nl_r, is_tab_r;
  logic [IDX_W-1:0]  idx_r;
  logic [COL_W-1:0]  set_col_r;
  logic [ROW_W-1:0]  set_row_r;

  logic              out_valid_r;
  cmd_t              out_cmd_r;
  logic              out_last_r;

  uword_t            uw;
  cmd_req_t          req;
  cmd_t              cmd;
  logic              accept, emitting, out_free, go, cond_true;
  logic [COL_W-1:0]  col_inc;
  logic              wrap_now, bottom, more_tab_now, glyph_last;
  logic [IDX_W-1:0]  in_idx;

  // column modulo tab stop
  logic [MOD_W-1:0]  col_mod [2**COL_W];
  for (genvar g = 0; g < 2**COL_W; g++) begin : g_col_mod
    assign col_mod[g] = MOD_W'(g % TAB_STOP);
  end

  assign uw       = ucode(step_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign emitting = (uw.emit != EMIT_NONE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign go       = (step_r != S_IDLE) && (!emitting || out_free);

  assign in_ch.ready = (step_r == S_IDLE);

  assign col_inc      = col_r + COL_W'(1);
  assign wrap_now     = (col_inc == COL_W'(COLS));
  assign bottom       = (row_r == ROW_W'(ROWS - 1));
  assign more_tab_now = is_tab_r && !wrap_now && (col_mod[col_inc] != '0);
  assign glyph_last   = wrap_now ? !bottom : !more_tab_now;

  always_comb begin
    if (in_ch.char_code == CODE_TAB) begin
      in_idx = '0;
    end else if (in_ch.char_code < 8'(FIRST_CODE) ||
                 in_ch.char_code >= 8'(FIRST_CODE + CODE_COUNT)) begin
      in_idx = IDX_W'(CODE_SUBST - CODE_SPACE);
    end else begin
      in_idx = IDX_W'(in_ch.char_code - CODE_SPACE);
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_SET_MODE:   cond_true = mode_r;
      C_IS_CR:      cond_true = is_cr_r;
      C_IS_NL:      cond_true = is_nl_r;
      C_MORE_TAB:   cond_true = is_tab_r && (col_mod[col_r] != '0);
      C_NO_WRAP:    cond_true = !wrap_r;
      C_NOT_BOTTOM: cond_true = !bottom;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    wrap_nxt = wrap_r;
    if (step_r == S_IDLE) begin
      if (accept) begin
        step_nxt = S_CHK_SET;
        wrap_nxt = 1'b0;
      end
    end else if (go) begin
      step_nxt = cond_true ? uw.target : step_r + STEP_W'(1);
      unique case (uw.act)
        ACT_ADVANCE: begin
          col_nxt  = wrap_now ? '0 : col_inc;
          wrap_nxt = wrap_now;
        end
        ACT_NEWLINE: begin
          col_nxt = '0;
          if (!bottom) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
        ACT_SET: begin
          col_nxt = set_col_r;
          row_nxt = set_row_r;
        end
        ACT_NONE: begin
        end
      endcase
    end
  end

  assign req = '{emit: uw.emit, idx: idx_r, col: col_r, row: row_r};

  tcbs_cmd_fmt #(
    .GLYPH_W      (GLYPH_W),
    .GLYPH_H      (GLYPH_H),
    .ATLAS_PER_ROW(ATLAS_PER_ROW)
  ) u_cmd_fmt (
    .req(req),
    .cmd(cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      wrap_r <= wrap_nxt;
      if (go && emitting) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_ch.mode;
      is_cr_r   <= (in_ch.char_code == CODE_CR);
      is_nl_r   <= (in_ch.char_code == CODE_NL);
      is_tab_r  <= (in_ch.char_code == CODE_TAB);
      idx_r     <= in_idx;
      set_col_r <= (in_ch.new_col >= 8'(COLS)) ? COL_W'(COLS - 1) : COL_W'(in_ch.new_col);
      set_row_r <= (in_ch.new_row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(in_ch.new_row);
    end
    if (go && emitting) begin
      out_cmd_r  <= cmd;
      out_last_r <= (uw.emit == EMIT_GLYPH) ? glyph_last : (uw.emit == EMIT_FILL);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.op     = out_cmd_r.op;
  assign out_ch.src_x  = out_cmd_r.src_x;
  assign out_ch.src_y  = out_cmd_r.src_y;
  assign out_ch.dst_x  = out_cmd_r.dst_x;
  assign out_ch.dst_y  = out_cmd_r.dst_y;
  assign out_ch.rect_w = out_cmd_r.rect_w;
  assign out_ch.rect_h = out_cmd_r.rect_h;
  assign out_ch.last   = out_last_r;

endmodule

### hw/rtl/tcbs_cmd_fmt.sv
module tcbs_cmd_fmt import tcbs_pkg::*; #(
  parameter int GLYPH_W       = 20,
  parameter int GLYPH_H       = 20,
  parameter int ATLAS_PER_ROW = 50
) (
  input  cmd_req_t req,
  output cmd_t     cmd
);

  // font atlas position of every glyph index
  logic [9:0] atlas_x [CODE_COUNT];
  logic [8:0] atlas_y [CODE_COUNT];

  for (genvar g = 0; g < CODE_COUNT; g++) begin : g_atlas
    assign atlas_x[g] = 10'((g % ATLAS_PER_ROW) * GLYPH_W);
    assign atlas_y[g] = 9'((g / ATLAS_PER_ROW) * GLYPH_H);
  end

  always_comb begin
    cmd = '0;
    unique case (req.emit)
      EMIT_GLYPH: begin
        cmd.op     = OP_GLYPH;
        cmd.src_x  = atlas_x[req.idx];
        cmd.src_y  = atlas_y[req.idx];
        cmd.dst_x  = 10'(16'(req.col) * 16'(GLYPH_W));
        cmd.dst_y  = 9'(14'(req.row) * 14'(GLYPH_H));
        cmd.rect_w = 10'(GLYPH_W);
        cmd.rect_h = 9'(GLYPH_H);
      end
      EMIT_SCROLL: begin
        cmd.op     = OP_SCROLL;
        cmd.src_y  = 9'(GLYPH_H);
        cmd.rect_w = 10'(SCREEN_W);
        cmd.rect_h = 9'(SCREEN_H - GLYPH_H);
      end
      EMIT_FILL: begin
        // blank fill of the bottom text row, no source
        cmd.op     = OP_FILL;
        cmd.dst_y  = 9'(SCREEN_H - GLYPH_H);
        cmd.rect_w = 10'(SCREEN_W);
        cmd.rect_h = 9'(GLYPH_H);
      end
      EMIT_NONE: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### test/text_console_blit_sequencer_core_tb.sv
`timescale 1ns / 100ps

module text_console_blit_sequencer_core_tb;
  import tcbs_pkg::*;

  localparam int COLS          = 40;
  localparam int ROWS          = 24;
  localparam int GLYPH_W       = 20;
  localparam int GLYPH_H       = 20;
  localparam int ATLAS_PER_ROW = 50;
  localparam int TAB_STOP      = 4;

  localparam logic MODE_PUT = 1'b0;
  localparam logic MODE_SET = 1'b1;

  localparam int N_RANDOM    = 74;
  localparam int TAIL_ITEMS  = 15;
  localparam int HOLD_AFTER  = 45;
  localparam int HOLD_CYCLES = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic       mode;
    logic [7:0] code;
    logic [7:0] col;
    logic [7:0] row;
    bit         drain;
  } console_req_t;

  typedef struct {
    cmd_t cmd;
    logic last;
  } blit_exp_t;

  logic clk;
  logic rst_n;

  tcbs_in_if  in_if();
  tcbs_out_if out_if();

  text_console_blit_sequencer_core #(
    .COLS          (COLS),
    .ROWS          (ROWS),
    .GLYPH_W       (GLYPH_W),
    .GLYPH_H       (GLYPH_H),
    .ATLAS_PER_ROW (ATLAS_PER_ROW),
    .TAB_STOP      (TAB_STOP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  console_req_t     req_q[$];
  blit_exp_t        blit_q[$];
  console_req_t     cur_req;
  blit_exp_t        want;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  int               gap_left;
  int               stall_left;
  int               hold_left;
  bit               hold_done;
  int               n_sent;
  int               n_errors;
  int               n_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cursor tracking and expected blit commands
  task automatic emit_blit(logic [1:0] op, int sx, int sy, int dx, int dy, int w, int h);
    blit_exp_t b;
    b.cmd.op     = op;
    b.cmd.src_x  = sx[9:0];
    b.cmd.src_y  = sy[8:0];
    b.cmd.dst_x  = dx[9:0];
    b.cmd.dst_y  = dy[8:0];
    b.cmd.rect_w = w[9:0];
    b.cmd.rect_h = h[8:0];
    b.last       = 1'b0;
    blit_q.push_back(b);
  endtask

  task automatic line_feed();
    cur_col = '0;
    if (cur_row + 1 < ROWS) begin
      cur_row = cur_row + 1'b1;
    end else begin
      emit_blit(OP_SCROLL, 0, GLYPH_H, 0, 0, SCREEN_W, SCREEN_H - GLYPH_H);
      emit_blit(OP_FILL, 0, 0, 0, SCREEN_H - GLYPH_H, SCREEN_W, GLYPH_H);
    end
  endtask

  task automatic draw_glyph(logic [7:0] code);
    int idx;
    if (code < FIRST_CODE || code >= FIRST_CODE + CODE_COUNT) begin
      idx = CODE_SUBST - FIRST_CODE;
    end else begin
      idx = code - FIRST_CODE;
    end
    emit_blit(OP_GLYPH, (idx % ATLAS_PER_ROW) * GLYPH_W, (idx / ATLAS_PER_ROW) * GLYPH_H,
              cur_col * GLYPH_W, cur_row * GLYPH_H, GLYPH_W, GLYPH_H);
    if (cur_col + 1 >= COLS) begin
      line_feed();
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  task automatic render_request(console_req_t r);
    int        n_prior;
    blit_exp_t tail;
    n_prior = blit_q.size();
    if (r.mode == MODE_SET) begin
      cur_col = (r.col >= COLS) ? COL_W'(COLS - 1) : r.col[COL_W-1:0];
      cur_row = (r.row >= ROWS) ? ROW_W'(ROWS - 1) : r.row[ROW_W-1:0];
    end else if (r.code == CODE_CR) begin
      // nothing drawn
    end else if (r.code == CODE_NL) begin
      line_feed();
    end else if (r.code == CODE_TAB) begin
      // at least one space, stop on a tab column or after a wrap
      do draw_glyph(CODE_SPACE); while (cur_col % TAB_STOP != 0);
    end else begin
      draw_glyph(r.code);
    end
    if (blit_q.size() > n_prior) begin
      tail = blit_q.pop_back();
      tail.last = 1'b1;
      blit_q.push_back(tail);
    end
  endtask

  task automatic cmp_field(string fname, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, exp_v, act_v);
      n_errors++;
    end
  endtask

  function automatic bit tail_phase();
    return req_q.size() < TAIL_ITEMS;
  endfunction

  task automatic add_put(logic [7:0] code, bit drain = 0);
    console_req_t r;
    r.mode  = MODE_PUT;
    r.code  = code;
    r.col   = 8'($urandom_range(0, 255));
    r.row   = 8'($urandom_range(0, 255));
    r.drain = drain;
    req_q.push_back(r);
  endtask

  task automatic add_set(logic [7:0] col, logic [7:0] row, bit drain = 0);
    console_req_t r;
    r.mode  = MODE_SET;
    r.code  = 8'($urandom_range(0, 255));
    r.col   = col;
    r.row   = row;
    r.drain = drain;
    req_q.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        render_request(cur_req);
        n_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].drain && blit_q.size() != 0)) begin
          if (!tail_phase() && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 3);
            in_if.valid <= 1'b0;
          end else begin
            cur_req = req_q.pop_front();
            in_if.valid     <= 1'b1;
            in_if.mode      <= cur_req.mode;
            in_if.char_code <= cur_req.code;
            in_if.new_col   <= cur_req.col;
            in_if.new_row   <= cur_req.row;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // command monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (blit_q.size() == 0) begin
          $display("%0t: unexpected command, actual op %0d dst_x %0d dst_y %0d last %0d",
                   $time, out_if.op, out_if.dst_x, out_if.dst_y, out_if.last);
          n_errors++;
        end else begin
          want = blit_q.pop_front();
          cmp_field("op", want.cmd.op, out_if.op);
          cmp_field("src_x", want.cmd.src_x, out_if.src_x);
          cmp_field("src_y", want.cmd.src_y, out_if.src_y);
          cmp_field("dst_x", want.cmd.dst_x, out_if.dst_x);
          cmp_field("dst_y", want.cmd.dst_y, out_if.dst_y);
          cmp_field("rect_w", want.cmd.rect_w, out_if.rect_w);
          cmp_field("rect_h", want.cmd.rect_h, out_if.rect_h);
          cmp_field("last", want.last, out_if.last);
        end
      end
      if (!hold_done && n_sent >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!tail_phase() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [7:0]  col;
    logic [7:0]  row;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_PUT;
    in_if.char_code = '0;
    in_if.new_col   = '0;
    in_if.new_row   = '0;
    out_if.ready    = 1'b0;
    cur_col         = '0;
    cur_row         = '0;
    n_sent          = 0;
    n_errors        = 0;
    n_cycles        = 0;
    hold_done       = 1'b0;

    // directed: code range edges, control codes, clamping, wrap and scroll
    add_put(8'h41);
    add_put(8'd0);
    add_put(8'd31);
    add_put(8'd32);
    add_put(8'd131);
    add_put(8'd132);
    add_put(8'd255);
    add_put(CODE_CR);
    add_put(CODE_TAB);
    add_put(CODE_NL);
    add_set(8'd255, 8'd255);
    add_put(8'h5a);
    add_put(CODE_NL);
    add_set(8'd36, 8'd23);
    add_put(CODE_TAB);
    add_set(8'd40, 8'd24);
    add_put(CODE_TAB);
    add_set(8'd0, 8'd0);
    add_put(CODE_TAB);
    add_set(8'd128, 8'd5);
    add_put(8'd127);
    add_set(8'd39, 8'd128);
    add_put(8'd64);
    add_set(8'd0, 8'd22);
    add_put(CODE_NL);
    add_put(CODE_NL);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        col = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, COLS - 1))
                                          : 8'($urandom_range(0, 255));
        row = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(ROWS - 4, ROWS - 1))
                                          : 8'($urandom_range(0, 255));
        add_set(col, row, i == 0 || i == 60);
      end else if (pick < 22) begin
        add_put(CODE_TAB, i == 0 || i == 60);
      end else if (pick < 32) begin
        add_put(CODE_NL, i == 0 || i == 60);
      end else if (pick < 37) begin
        add_put(CODE_CR, i == 0 || i == 60);
      end else if (pick < 50) begin
        add_put(8'($urandom_range(0, 255)), i == 0 || i == 60);
      end else begin
        add_put(8'($urandom_range(FIRST_CODE, FIRST_CODE + CODE_COUNT - 1)),
                i == 0 || i == 60);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_if.valid) @(posedge clk);
    while (blit_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
